// ----- hdl/bpa_pkg.sv -----
// shared types and constants for the buddy page allocator
`default_nettype none
package bpa_pkg;

  // pool geometry
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned NUM_ORDERS = 10;
  localparam int unsigned NUM_PAGES  = 1024;

  // request modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_DONATE = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // field widths fixed by the interface
  localparam int unsigned BYTES_W  = 22;
  localparam int unsigned PAGE_W   = 10;
  localparam int unsigned ORDER_W  = 4;
  localparam int unsigned COUNT_W  = 11;

  // sequencer states
  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_SIZE    = 13'b0000000000100,
    S_SEARCH  = 13'b0000000001000,
    S_FETCH   = 13'b0000000010000,
    S_TAKE    = 13'b0000000100000,
    S_SPLIT   = 13'b0000001000000,
    S_BUDDY   = 13'b0000010000000,
    S_BUDDY2  = 13'b0000100000000,
    S_REMOVE  = 13'b0001000000000,
    S_REMOVE2 = 13'b0010000000000,
    S_APPEND  = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

endpackage : bpa_pkg
`default_nettype wire

// ----- hdl/buddy_page_allocator_core.sv -----
// buddy page allocator top level: sequencer, free lists, bitmaps and counters
// an allocation runs a size scan, an order search and a split; a free coalesces
//   with its buddy order by order
// requests: one at a time; in_stall is high outside the idle state
// reset: synchronous, empties lists and counters, then a clearing pass marks
//   every bitmap entry busy with the input stalled; link memories are not cleared
`default_nettype none
module buddy_page_allocator_core
  import bpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic [BYTES_W-1:0] request_bytes,
  input  wire logic [PAGE_W-1:0]  page_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [PAGE_W-1:0]       granted_page,
  output logic [ORDER_W-1:0]      granted_order,
  output logic [COUNT_W-1:0]      used_pages,
  output logic [COUNT_W-1:0]      peak_used_pages
);

  localparam int unsigned BITS    = 2 * NUM_PAGES;
  localparam int unsigned BA_W    = $clog2(BITS);
  localparam int unsigned PI_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned OK_W    = $clog2(NUM_ORDERS + 1);
  localparam logic [COUNT_W:0] USED_MAX = (COUNT_W+1)'(2 * NUM_PAGES - 1);

  // per-order list heads/tails
  logic [PI_W-1:0]       head [NUM_ORDERS];
  logic [PI_W-1:0]       tail [NUM_ORDERS];
  logic [NUM_ORDERS-1:0] lvalid;

  // link memories and bitmap memory
  logic [PI_W-1:0] next_mem [NUM_PAGES];
  logic [PI_W-1:0] prev_mem [NUM_PAGES];
  logic            busy_mem [BITS];
  logic [BA_W-1:0] clr;

  state_t state;
  logic [1:0]          r_mode;
  logic [BYTES_W-1:0]  r_bytes;
  logic [PI_W-1:0]     r_page;
  logic [OK_W-1:0]     m, k;
  logic [PI_W:0]       idx;
  logic [PI_W-1:0]     c;
  logic [COUNT_W:0]    used, peak;
  logic [PI_W-1:0]     rd_next, rd_prev;
  logic                rd_busy;
  logic [PI_W-1:0]     x;
  logic [1:0]          res_status;
  logic [PI_W-1:0]     res_page;
  logic [ORDER_W-1:0]  res_order;

  // bitmap base offset of order k: sum of the row sizes below it
  function automatic logic [BA_W:0] base_of(input logic [OK_W-1:0] kk);
    return (BA_W+1)'(BITS) - ((BA_W+1)'(BITS) >> kk);
  endfunction

  logic [BA_W:0] bpos;
  logic          in_pool;
  logic [PI_W:0] bud;
  assign bud     = idx ^ (PI_W+1)'(1);
  assign in_pool = ((PI_W+1)'(bud) < (PI_W+1)'(NUM_PAGES >> k));
  assign bpos    = base_of(k) + (BA_W+1)'(bud);

  // memory reads (registered)
  always_ff @(posedge clk) begin
    rd_next <= next_mem[x];
    rd_prev <= prev_mem[x];
    rd_busy <= busy_mem[bpos[BA_W-1:0]];
  end

  // size decode helpers
  logic [BYTES_W:0] unit;
  assign unit = (BYTES_W+1)'(1) << (PAGE_SHIFT + 32'(m));
  logic pow2;
  assign pow2 = (r_bytes != '0) && ((r_bytes & (r_bytes - 1'b1)) == '0);

  logic [PI_W:0] chunk_end;
  assign chunk_end = (PI_W+1)'(r_page) + ((PI_W+1)'(1) << m);

  logic bud_busy;
  assign bud_busy = !in_pool || rd_busy;

  logic [PI_W-1:0] idx_page;
  assign idx_page = PI_W'(idx << k);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      lvalid    <= '0;
      used      <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      // result handshake
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        // mark every bitmap entry busy after reset
        S_CLEAR: begin
          busy_mem[clr] <= 1'b1;
          if (clr == BA_W'(BITS - 1)) state <= S_IDLE;
          clr <= clr + 1'b1;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            r_mode  <= mode;
            r_bytes <= request_bytes;
            r_page  <= PI_W'(page_index);
            m       <= '0;
            res_page  <= '0;
            res_order <= '0;
            if (mode == MODE_DONATE && 32'(page_index) < NUM_PAGES) begin
              k   <= '0;
              idx <= (PI_W+1)'(page_index);
              x   <= PI_W'((PI_W+1)'(page_index) ^ 1);
              res_status <= ST_OK;
              state      <= S_BUDDY;
            end else begin
              res_status <= ST_BAD;
              if (mode == MODE_DONATE || mode == MODE_RSVD) state <= S_DONE;
              else state <= S_SIZE;
            end
          end
        end
        // one order per cycle: find the smallest order covering the size, then search or free
        S_SIZE: begin
          if (32'(m) < NUM_ORDERS && (BYTES_W+1)'(r_bytes) > unit) m <= m + 1'b1;
          else if (32'(m) >= NUM_ORDERS) state <= S_DONE;
          else if (r_mode == MODE_ALLOC) begin
            k <= m; state <= S_SEARCH;
          end else begin
            if (pow2 && (BYTES_W+1)'(r_bytes) == unit &&
                (r_page & PI_W'((1 << m) - 1)) == '0 &&
                32'(chunk_end) <= NUM_PAGES) begin
              used   <= (used > ((COUNT_W+1)'(1) << m)) ?
                        used - ((COUNT_W+1)'(1) << m) : '0;
              k      <= m;
              idx    <= (PI_W+1)'(r_page >> m);
              x      <= PI_W'(((r_page >> m) ^ 1) << m);
              res_status <= ST_OK;
              state  <= S_BUDDY;
            end else state <= S_DONE;
          end
        end
        S_SEARCH: begin
          if (32'(k) >= NUM_ORDERS) begin
            res_status <= ST_NOSPACE; state <= S_DONE;
          end else if (lvalid[k]) begin
            c <= head[k]; x <= head[k]; state <= S_FETCH;
          end else k <= k + 1'b1;
        end
        // wait for the link read of the head page
        S_FETCH: state <= S_TAKE;
        // pop head, mark busy
        S_TAKE: begin
          if (head[k] == tail[k]) lvalid[k] <= 1'b0;
          else head[k] <= rd_next;
          busy_mem[BA_W'(base_of(k) + (BA_W+1)'(c >> k))] <= 1'b1;
          state <= S_SPLIT;
        end
        // append upper halves downward
        S_SPLIT: begin
          if (k > m) begin
            logic [PI_W-1:0] b;
            logic [OK_W-1:0] kn;
            kn = k - 1'b1;
            b  = c + PI_W'(1 << kn);
            if (lvalid[kn]) begin
              next_mem[tail[kn]] <= b;
              prev_mem[b] <= tail[kn];
            end else begin
              head[kn] <= b; lvalid[kn] <= 1'b1;
            end
            tail[kn] <= b;
            busy_mem[BA_W'(base_of(kn) + (BA_W+1)'(b >> kn))] <= 1'b0;
            k <= kn;
          end else begin
            used <= ((used + ((COUNT_W+1)'(1) << m)) > USED_MAX) ? USED_MAX :
                    used + ((COUNT_W+1)'(1) << m);
            res_status <= ST_OK;
            res_page   <= PI_W'(c);
            res_order  <= ORDER_W'(m);
            state <= S_DONE;
          end
        end
        // wait for buddy bitmap and links of buddy page
        S_BUDDY: state <= S_BUDDY2;
        S_BUDDY2: begin
          if (32'(k) < NUM_ORDERS - 1 && !bud_busy) begin
            busy_mem[bpos[BA_W-1:0]] <= 1'b1;
            state <= S_REMOVE;
          end else state <= S_APPEND;
        end
        // unlink buddy page x from list k
        S_REMOVE: begin
          if (lvalid[k]) begin
            if (head[k] == x && tail[k] == x) lvalid[k] <= 1'b0;
            else if (head[k] == x) head[k] <= rd_next;
            else if (tail[k] == x) tail[k] <= rd_prev;
            else begin
              next_mem[rd_prev] <= rd_next;
              prev_mem[rd_next] <= rd_prev;
            end
          end
          state <= S_REMOVE2;
        end
        S_REMOVE2: begin
          idx <= idx >> 1;
          k   <= k + 1'b1;
          x   <= PI_W'((((idx >> 1) ^ 1)) << (k + 1'b1));
          state <= S_BUDDY;
        end
        S_APPEND: begin
          if (32'(idx) < (NUM_PAGES >> k))
            busy_mem[BA_W'(base_of(k) + (BA_W+1)'(idx))] <= 1'b0;
          if (lvalid[k]) begin
            next_mem[tail[k]] <= idx_page;
            prev_mem[idx_page] <= tail[k];
          end else begin
            head[k] <= idx_page; lvalid[k] <= 1'b1;
          end
          tail[k] <= idx_page;
          state <= S_DONE;
        end
        // load the result register once it is free
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            status        <= res_status;
            granted_page  <= PAGE_W'(res_page);
            granted_order <= res_order;
            used_pages    <= COUNT_W'(used);
            if (used > peak) begin
              peak            <= used;
              peak_used_pages <= COUNT_W'(used);
            end else begin
              peak_used_pages <= COUNT_W'(peak);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule : buddy_page_allocator_core
`default_nettype wire
